### src/vrt_pkg.sv
// Shared types, constants and codes for the voxel ray traversal block.
package vrt_pkg;

    localparam int COORD_INT_BITS = 16;
    localparam int CW = COORD_INT_BITS;

    localparam logic [31:0] T_MAX_VAL = 32'hFFFF_FFFF;
    localparam logic [31:0] REACH_RST = 32'd524288;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_ANSWER = 1'b1;

    // Divider request and response between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [45:0] num;
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

endpackage

### src/vrt_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, saturated to 32 bits.
module vrt_div
    import vrt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [45:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [16:0] w_trial;
    logic [16:0] w_sub;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[15:0], r_q[45]};
        w_sub   = w_trial - {1'b0, r_den};
        if (i_req.start) begin
            n_q    = i_req.num;
            n_rem  = '0;
            n_cnt  = 6'd46;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_sub;
                n_q   = {r_q[44:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[44:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_q[45:32] != '0) ? T_MAX_VAL : r_q[31:0];

endmodule

### src/voxel_ray_traversal.sv
// Top level: ray setup sequencer around a shared serial divider, and the DDA stepper.
// A start item runs two divisions per nonzero direction axis plus a pass through ST_SETUP
// per axis; its query or miss is then loaded into the output register from ST_EMIT.
// An answer's result is loaded into the output register from ST_OUT, after ST_STEP on a step;
// the input takes one item at a time, only in ST_IDLE, and a full output register holds it back.
// Reset (synchronous, active low) drops any ray and sets max_reach to 8.0.
module voxel_ray_traversal
    import vrt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (bits 0..143)
    input  logic [191:0] s_axis_tdata,
    // tuser: func (bit 0), solid (bit 1)
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: voxel_x, voxel_y, voxel_z, normal_x, normal_y, normal_z,
    //        hit_distance (bits 0..85), zero fill to 88
    output logic [87:0]  m_axis_tdata,
    // tuser: kind
    output logic [1:0]   m_axis_tuser
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_STEP  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]  r_st, n_st;
    logic [31:0] r_reach;
    logic        r_active;
    logic [CW-1:0] r_cell [3];
    logic [1:0]  r_step [3];
    logic [31:0] r_tn [3];
    logic [31:0] r_td [3];
    logic [31:0] r_trav;
    logic [1:0]  r_norm [3];
    logic [15:0] r_frac [3];
    logic [15:0] r_mag [3];
    logic [1:0]  r_ax;
    logic        r_sub;     // 0: t_delta division, 1: t_next division
    logic [1:0]  r_sel;
    logic        r_hit;

    logic        r_ovalid;
    logic [1:0]  r_okind;
    logic [87:0] r_odata;

    t_div_req w_req;
    t_div_rsp w_rsp;

    vrt_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic w_acc;
    logic w_start;
    logic w_oslot;
    logic w_oload;
    logic [15:0] w_dir [3];
    logic [31:0] w_org [3];
    logic [16:0] w_num;
    logic [32:0] w_sum;
    logic [CW-1:0] w_cell;

    assign s_axis_tready = (r_st == ST_IDLE);
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_start = s_axis_tuser[0] == FUNC_START;
    // The output register can take a new result when it is empty or draining.
    assign w_oslot = !r_ovalid || m_axis_tready;
    assign w_oload = ((r_st == ST_EMIT) || (r_st == ST_OUT)) && w_oslot;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_org[a] = s_axis_tdata[32*a +: 32];
            w_dir[a] = s_axis_tdata[96 + 16*a +: 16];
        end
    end

    // Divider numerator: 2^30 for t_delta, remaining fraction << 14 for t_next.
    always_comb begin
        w_num = r_step[r_ax] == 2'b11 ? {1'b0, r_frac[r_ax]}
                                      : 17'h10000 - {1'b0, r_frac[r_ax]};
        w_req.start = (r_st == ST_DIV);
        w_req.den   = r_mag[r_ax];
        w_req.num   = r_sub ? {15'd0, w_num, 14'd0} : 46'(64'd1 << 30);
    end

    assign w_sum  = {1'b0, r_tn[r_sel]} + {1'b0, r_td[r_sel]};
    assign w_cell = r_cell[r_sel] + {{(CW-2){r_step[r_sel][1]}}, r_step[r_sel]};

    function automatic logic [15:0] cell_out(input logic [CW-1:0] c);
        logic [31:0] v;
        v = 32'(signed'(c));
        return v[15:0];
    endfunction

    function automatic logic [CW-1:0] org_cell(input logic [31:0] o);
        logic [31:0] v;
        v = 32'(signed'(o[31:16]));
        return v[CW-1:0];
    endfunction

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_acc && w_start) begin
                    n_st = ST_SETUP;
                end else if (w_acc && r_active) begin
                    n_st = s_axis_tuser[1] ? ST_OUT : ST_STEP;
                end
            end
            ST_SETUP: begin
                if (r_ax == 2'd3) begin
                    n_st = ST_EMIT;
                end else if (r_step[r_ax] != 2'b00) begin
                    n_st = ST_DIV;
                end
            end
            ST_DIV:  n_st = ST_WAIT;
            ST_WAIT: begin
                if (w_rsp.done) begin
                    n_st = r_sub ? ST_SETUP : ST_DIV;
                end
            end
            ST_EMIT: begin
                if (w_oslot) begin
                    n_st = ST_IDLE;
                end
            end
            ST_STEP: n_st = ST_OUT;
            ST_OUT: begin
                if (w_oslot) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_reach  <= REACH_RST;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_reach <= i_cfg_wdata;
            end
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_st <= n_st;
            case (r_st)
                ST_IDLE: begin
                    if (w_acc && w_start) begin
                        r_ax  <= 2'd0;
                        r_sub <= 1'b0;
                        r_trav <= '0;
                        for (int a = 0; a < 3; a++) begin
                            r_cell[a] <= org_cell(w_org[a]);
                            r_frac[a] <= w_org[a][15:0];
                            r_mag[a]  <= w_dir[a][15] ? 16'(17'h10000 - {1'b0, w_dir[a]})
                                                      : w_dir[a];
                            r_step[a] <= (w_dir[a] == '0) ? 2'b00
                                       : (w_dir[a][15] ? 2'b11 : 2'b01);
                            r_tn[a]   <= T_MAX_VAL;
                            r_td[a]   <= T_MAX_VAL;
                            r_norm[a] <= 2'b00;
                        end
                        r_active <= 1'b0;
                    end else if (w_acc && r_active) begin
                        r_hit <= s_axis_tuser[1];
                        if (r_tn[0] < r_tn[1]) begin
                            r_sel <= (r_tn[0] < r_tn[2]) ? 2'd0 : 2'd2;
                        end else begin
                            r_sel <= (r_tn[1] < r_tn[2]) ? 2'd1 : 2'd2;
                        end
                    end
                end
                ST_SETUP: begin
                    // Zero-direction axes keep their saturated values and are skipped.
                    if (r_ax != 2'd3 && r_step[r_ax] == 2'b00) begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                ST_WAIT: begin
                    if (w_rsp.done) begin
                        if (r_sub) begin
                            r_tn[r_ax] <= w_rsp.quot;
                            r_sub      <= 1'b0;
                            r_ax       <= r_ax + 2'd1;
                        end else begin
                            r_td[r_ax] <= w_rsp.quot;
                            r_sub      <= 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_oslot) begin
                        if (r_reach != '0) begin
                            r_active <= 1'b1;
                            r_okind  <= KIND_QUERY;
                            r_odata  <= {40'd0, cell_out(r_cell[2]), cell_out(r_cell[1]),
                                         cell_out(r_cell[0])};
                        end else begin
                            r_okind <= KIND_MISS;
                            r_odata <= '0;
                        end
                    end
                end
                ST_STEP: begin
                    r_cell[r_sel] <= w_cell;
                    r_trav        <= r_tn[r_sel];
                    r_tn[r_sel]   <= w_sum[32] ? T_MAX_VAL : w_sum[31:0];
                    for (int b = 0; b < 3; b++) begin
                        r_norm[b] <= (2'(b) == r_sel) ? 2'(-r_step[r_sel]) : 2'b00;
                    end
                end
                ST_OUT: begin
                    if (w_oslot) begin
                        if (r_hit) begin
                            r_active <= 1'b0;
                            r_okind  <= KIND_HIT;
                            r_odata  <= {2'd0, r_trav, r_norm[2], r_norm[1], r_norm[0],
                                         cell_out(r_cell[2]), cell_out(r_cell[1]),
                                         cell_out(r_cell[0])};
                        end else if (r_trav < r_reach) begin
                            r_okind <= KIND_QUERY;
                            r_odata <= {40'd0, cell_out(r_cell[2]), cell_out(r_cell[1]),
                                        cell_out(r_cell[0])};
                        end else begin
                            r_active <= 1'b0;
                            r_okind  <= KIND_MISS;
                            r_odata  <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;

endmodule
